@@ design/dprp_pkg.sv @@
package dprp_pkg;

  localparam int ADDRESS_BITS = 64;

  // Byte-queue between front and back end
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Framing bytes
  localparam logic [7:0] BYTE_INTR  = 8'h03;
  localparam logic [7:0] BYTE_OPEN  = 8'h24;  // '$'
  localparam logic [7:0] BYTE_CLOSE = 8'h23;  // '#'
  localparam logic [7:0] BYTE_COMMA = 8'h2C;  // ','
  localparam logic [7:0] BYTE_MINUS = 8'h2D;  // '-'

  // Register indexes on the APB port
  localparam logic [1:0] REG_NO_ACK    = 2'd0;
  localparam logic [1:0] REG_EXEC_OK   = 2'd1;
  localparam logic [1:0] REG_QUERY_TID = 2'd2;

  typedef enum logic [3:0] {
    KIND_INTERRUPT  = 4'd0,
    KIND_SET_CONT   = 4'd1,
    KIND_SET_QUERY  = 4'd2,
    KIND_GET_REGS   = 4'd3,
    KIND_GET_REG    = 4'd4,
    KIND_GET_MEM    = 4'd5,
    KIND_ALIVE      = 4'd6,
    KIND_SET_BREAK  = 4'd7,
    KIND_DEL_BREAK  = 4'd8,
    KIND_STOP_WHY   = 4'd9,
    KIND_WRITE_REF  = 4'd10,
    KIND_DETACH     = 4'd11,
    KIND_KILL       = 4'd12,
    KIND_UNSUP      = 4'd13,
    KIND_ALLSTOP    = 4'd14
  } kind_t;

  typedef struct packed {
    logic               no_ack;
    logic               exec_ok;
    logic signed [31:0] query_tid;
  } cfg_t;

  // Byte as classified by the front end
  typedef struct packed {
    logic [7:0] raw;
    logic       is_open;
    logic       is_close;
    logic       is_intr;
    logic       is_comma;
    logic       is_minus;
    logic       is_hex;
    logic [3:0] digit;
  } byte_class_t;

  typedef struct packed {
    kind_t              request_kind;
    logic signed [31:0] thread_id;
    logic [63:0]        address;
    logic [31:0]        length;
    logic [7:0]         register_index;
    logic [2:0]         watch_kind;
    logic               send_ack;
    logic               malformed;
  } result_t;

endpackage

@@ design/dprp_if.sv @@
interface dprp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface dprp_result_if;
  logic               valid;
  logic               ready;
  logic [3:0]         request_kind;
  logic signed [31:0] thread_id;
  logic [63:0]        address;
  logic [31:0]        length;
  logic [7:0]         register_index;
  logic [2:0]         watch_kind;
  logic               send_ack;
  logic               malformed;

  modport source (output valid, output request_kind, output thread_id, output address,
                  output length, output register_index, output watch_kind,
                  output send_ack, output malformed, input ready);
  modport sink   (input valid, input request_kind, input thread_id, input address,
                  input length, input register_index, input watch_kind,
                  input send_ack, input malformed, output ready);
endinterface

@@ design/debug_packet_request_parser_top.sv @@
// Path: a result word is held in the parser's output register once the byte that ends it
//   ('#' or 0x03) has passed through the byte queue and been taken by the parser.
// Throughput: one byte per cycle; the parser consumes a queued byte every cycle the
//   output register is empty or being taken.
// Reset (rst, synchronous, active high): registers read zero, parser hunts for '$',
//   queue and output register empty.
module debug_packet_request_parser_top (
  input  logic          clk,
  input  logic          rst,
  dprp_byte_if.sink     byte_chan,
  dprp_result_if.source result_chan,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import dprp_pkg::*;

  cfg_t        cfg;
  logic        push_valid;
  logic        push_ready;
  byte_class_t push_word;
  logic        q_valid;
  byte_class_t q_word;
  logic        q_pop;
  logic [1:0]  reg_idx;
  logic        wr_en;

  // APB register file: word aligned, index taken from paddr[3:2]
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_NO_ACK:    cfg.no_ack    <= pwdata[0];
        REG_EXEC_OK:   cfg.exec_ok   <= pwdata[0];
        REG_QUERY_TID: cfg.query_tid <= pwdata;
        default: begin
          // unmapped word: write dropped
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NO_ACK:    prdata = {31'd0, cfg.no_ack};
      REG_EXEC_OK:   prdata = {31'd0, cfg.exec_ok};
      REG_QUERY_TID: prdata = cfg.query_tid;
      default:       prdata = '0;
    endcase
  end

  // Front end: classifies each incoming byte (framing, separator, hex digit)
  dprp_front u_front (
    .byte_chan  (byte_chan),
    .push_valid (push_valid),
    .push_word  (push_word),
    .push_ready (push_ready)
  );

  // Short queue so the link side keeps flowing while a result waits
  dprp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_word  (push_word),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_word   (q_word),
    .pop        (q_pop)
  );

  // Back end: packet state machine, field accumulators and result register
  dprp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_word      (q_word),
    .q_pop       (q_pop),
    .result_chan (result_chan)
  );

endmodule

@@ design/dprp_front.sv @@
module dprp_front (
  dprp_byte_if.sink            byte_chan,
  output logic                 push_valid,
  output dprp_pkg::byte_class_t push_word,
  input  logic                 push_ready
);
  import dprp_pkg::*;

  logic [7:0] b;

  assign b = byte_chan.byte_in;

  always_comb begin
    push_word          = '0;
    push_word.raw      = b;
    push_word.is_open  = (b == BYTE_OPEN);
    push_word.is_close = (b == BYTE_CLOSE);
    push_word.is_intr  = (b == BYTE_INTR);
    push_word.is_comma = (b == BYTE_COMMA);
    push_word.is_minus = (b == BYTE_MINUS);
    if (b inside {[8'h30:8'h39]}) begin
      push_word.is_hex = 1'b1;
      push_word.digit  = b[3:0];
    end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      push_word.is_hex = 1'b1;
      push_word.digit  = b[3:0] + 4'd9;
    end
  end

  assign push_valid      = byte_chan.valid;
  assign byte_chan.ready = push_ready;

endmodule

@@ design/dprp_queue.sv @@
module dprp_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  input  dprp_pkg::byte_class_t push_word,
  output logic                  push_ready,
  output logic                  pop_valid,
  output dprp_pkg::byte_class_t pop_word,
  input  logic                  pop
);
  import dprp_pkg::*;

  byte_class_t          slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count < QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_word   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

@@ design/dprp_back.sv @@
module dprp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  dprp_pkg::cfg_t        cfg,
  input  logic                  q_valid,
  input  dprp_pkg::byte_class_t q_word,
  output logic                  q_pop,
  dprp_result_if.source         result_chan
);
  import dprp_pkg::*;

  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_QL = 8'h71;
  localparam logic [7:0] CH_QU = 8'h51;
  localparam logic [7:0] CH_GL = 8'h67;
  localparam logic [7:0] CH_GU = 8'h47;
  localparam logic [7:0] CH_MU = 8'h4D;
  localparam logic [7:0] CH_PU = 8'h50;
  localparam logic [7:0] CH_X = 8'h58;
  localparam logic [7:0] CH_K = 8'h6B;
  localparam logic [7:0] CH_ML = 8'h6D;
  localparam logic [7:0] CH_PL = 8'h70;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_ZL = 8'h7A;
  localparam logic [7:0] CH_ZU = 8'h5A;
  localparam logic [7:0] CH_QM = 8'h3F;
  localparam logic [7:0] CH_C = 8'h63;

  typedef enum logic [1:0] {
    HUNT,
    LETTER,
    FIELDS
  } mode_t;

  mode_t                   mode, mode_next;
  logic [7:0]              letter, letter_next;
  logic [1:0]              field_no, field_no_next;
  logic [ADDRESS_BITS-1:0] addr_acc, addr_acc_next;
  logic [31:0]             len_acc, len_acc_next;
  logic [31:0]             tid_acc, tid_acc_next;
  logic                    minus_seen, minus_seen_next;
  logic                    cont_sel, cont_sel_next;
  logic [2:0]              wk_acc, wk_acc_next;
  logic                    err_seen, err_seen_next;

  logic        out_valid;
  result_t     out_word;
  result_t     res;
  logic        emit;
  logic        load;
  kind_t       kind;
  logic [31:0] p_shift;
  logic [7:0]  b;
  logic [3:0]  d;

  assign load  = q_valid && (!out_valid || result_chan.ready);
  assign q_pop = load;
  assign b     = q_word.raw;
  assign d     = q_word.digit;
  assign p_shift = {len_acc[27:0], d};

  // Request kind at the closing byte
  always_comb begin
    case (letter)
      CH_D:         kind = KIND_DETACH;
      CH_H:         kind = cont_sel ? KIND_SET_CONT : KIND_SET_QUERY;
      CH_QL, CH_QU: kind = KIND_UNSUP;
      default: begin
        if (!cfg.exec_ok) begin
          kind = KIND_ALLSTOP;
        end else begin
          case (letter)
            CH_GL:                    kind = KIND_GET_REGS;
            CH_GU, CH_MU, CH_PU, CH_X: kind = KIND_WRITE_REF;
            CH_K:                     kind = KIND_KILL;
            CH_ML:                    kind = KIND_GET_MEM;
            CH_PL:                    kind = KIND_GET_REG;
            CH_T:                     kind = KIND_ALIVE;
            CH_ZL:                    kind = KIND_DEL_BREAK;
            CH_ZU:                    kind = KIND_SET_BREAK;
            CH_QM:                    kind = KIND_STOP_WHY;
            default:                  kind = KIND_UNSUP;
          endcase
        end
      end
    endcase
  end

  always_comb begin
    mode_next       = mode;
    letter_next     = letter;
    field_no_next   = field_no;
    addr_acc_next   = addr_acc;
    len_acc_next    = len_acc;
    tid_acc_next    = tid_acc;
    minus_seen_next = minus_seen;
    cont_sel_next   = cont_sel;
    wk_acc_next     = wk_acc;
    err_seen_next   = err_seen;
    emit            = 1'b0;
    res             = '0;
    res.request_kind = KIND_INTERRUPT;

    if (load) begin
      case (mode)
        HUNT: begin
          if (q_word.is_open) begin
            mode_next       = LETTER;
            letter_next     = '0;
            field_no_next   = '0;
            addr_acc_next   = '0;
            len_acc_next    = '0;
            tid_acc_next    = '0;
            minus_seen_next = 1'b0;
            cont_sel_next   = 1'b0;
            wk_acc_next     = '0;
            err_seen_next   = 1'b0;
          end else if (q_word.is_intr) begin
            emit             = 1'b1;
            res.request_kind = cfg.exec_ok ? KIND_INTERRUPT : KIND_ALLSTOP;
          end
        end
        default: begin
          if (q_word.is_close) begin
            emit             = 1'b1;
            mode_next        = HUNT;
            res.request_kind = kind;
            res.send_ack     = !cfg.no_ack;
            case (kind)
              KIND_SET_CONT, KIND_SET_QUERY, KIND_ALIVE: begin
                res.thread_id = minus_seen ? (32'd0 - tid_acc) : tid_acc;
                res.malformed = err_seen;
              end
              KIND_GET_REGS, KIND_STOP_WHY: begin
                res.thread_id = cfg.query_tid;
              end
              KIND_GET_REG: begin
                res.thread_id      = cfg.query_tid;
                res.register_index = len_acc[7:0];
                res.malformed      = err_seen;
              end
              KIND_GET_MEM: begin
                res.thread_id = cfg.query_tid;
                res.address   = 64'(addr_acc);
                res.length    = len_acc;
                res.malformed = err_seen || (field_no != 2'd1);
              end
              KIND_SET_BREAK, KIND_DEL_BREAK: begin
                res.address    = 64'(addr_acc);
                res.length     = len_acc;
                res.watch_kind = wk_acc;
                res.malformed  = err_seen || (field_no != 2'd2);
              end
              default: begin
              end
            endcase
          end else if (mode == LETTER) begin
            letter_next   = b;
            field_no_next = (b == CH_T) ? 2'd1 : 2'd0;
            mode_next     = FIELDS;
          end else begin
            case (letter)
              CH_H, CH_T: begin
                if (letter == CH_H && field_no == 2'd0) begin
                  cont_sel_next = (b == CH_C);
                  field_no_next = 2'd1;
                end else if (q_word.is_minus && field_no == 2'd1 && !minus_seen) begin
                  minus_seen_next = 1'b1;
                end else if (q_word.is_hex) begin
                  tid_acc_next  = {tid_acc[27:0], d};
                  field_no_next = 2'd2;
                end else begin
                  err_seen_next = 1'b1;
                end
              end
              CH_PL: begin
                if (q_word.is_hex) begin
                  // register number is held to 8 bits; anything above is an error
                  len_acc_next = {24'd0, p_shift[7:0]};
                  if (p_shift[31:8] != '0) begin
                    err_seen_next = 1'b1;
                  end
                end else begin
                  err_seen_next = 1'b1;
                end
              end
              CH_ML: begin
                if (q_word.is_hex) begin
                  if (field_no == 2'd0) begin
                    addr_acc_next = {addr_acc[ADDRESS_BITS-5:0], d};
                  end else begin
                    len_acc_next = p_shift;
                  end
                end else if (q_word.is_comma && field_no == 2'd0) begin
                  field_no_next = 2'd1;
                end else begin
                  err_seen_next = 1'b1;
                end
              end
              CH_ZL, CH_ZU: begin
                if (q_word.is_hex) begin
                  if (field_no == 2'd0) begin
                    if (wk_acc != '0 || d > 4'd4) begin
                      err_seen_next = 1'b1;
                      wk_acc_next   = 3'd4;
                    end else begin
                      wk_acc_next = d[2:0];
                    end
                  end else if (field_no == 2'd1) begin
                    addr_acc_next = {addr_acc[ADDRESS_BITS-5:0], d};
                  end else begin
                    len_acc_next = p_shift;
                  end
                end else if (q_word.is_comma && field_no < 2'd2) begin
                  field_no_next = field_no + 2'd1;
                end else begin
                  err_seen_next = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= HUNT;
      letter     <= '0;
      field_no   <= '0;
      addr_acc   <= '0;
      len_acc    <= '0;
      tid_acc    <= '0;
      minus_seen <= 1'b0;
      cont_sel   <= 1'b0;
      wk_acc     <= '0;
      err_seen   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      mode       <= mode_next;
      letter     <= letter_next;
      field_no   <= field_no_next;
      addr_acc   <= addr_acc_next;
      len_acc    <= len_acc_next;
      tid_acc    <= tid_acc_next;
      minus_seen <= minus_seen_next;
      cont_sel   <= cont_sel_next;
      wk_acc     <= wk_acc_next;
      err_seen   <= err_seen_next;
      if (load && emit) begin
        out_valid <= 1'b1;
      end else if (result_chan.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && emit) begin
      out_word <= res;
    end
  end

  assign result_chan.valid          = out_valid;
  assign result_chan.request_kind   = out_word.request_kind;
  assign result_chan.thread_id      = out_word.thread_id;
  assign result_chan.address        = out_word.address;
  assign result_chan.length         = out_word.length;
  assign result_chan.register_index = out_word.register_index;
  assign result_chan.watch_kind     = out_word.watch_kind;
  assign result_chan.send_ack       = out_word.send_ack;
  assign result_chan.malformed      = out_word.malformed;

  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result_chan.ready) |-> !q_pop)
    else $error("byte consumed while result stalled");

  a_malformed_kinds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.malformed) |->
      (out_word.request_kind == KIND_SET_CONT || out_word.request_kind == KIND_SET_QUERY ||
       out_word.request_kind == KIND_GET_REG || out_word.request_kind == KIND_GET_MEM ||
       out_word.request_kind == KIND_ALIVE || out_word.request_kind == KIND_SET_BREAK ||
       out_word.request_kind == KIND_DEL_BREAK))
    else $error("malformed flagged on wrong kind");

  a_hunt_result: assert property (@(posedge clk) disable iff (rst)
    (load && emit && mode == HUNT) |=>
      (!out_word.send_ack &&
       (out_word.request_kind == KIND_INTERRUPT || out_word.request_kind == KIND_ALLSTOP)))
    else $error("result outside packet is not an interrupt");

  a_watch_range: assert property (@(posedge clk) disable iff (rst)
    wk_acc <= 3'd4)
    else $error("watch type accumulator out of range");

endmodule
